### rtl/core/pcci_pkg.sv
// Package for the clamped-integral PID controller.
// Holds the shared widths, codes, state type and the saturation helper.
// No dependencies.
`default_nettype none
package pcci_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int REG_W       = 32;
  localparam int WIDE_W      = 64;
  localparam int MAG_W       = 64;
  localparam int MUL_CNT_W   = $clog2(MAG_W);
  localparam int PROD_W      = 2 * MAG_W;
  localparam int NUM_W       = 80;
  localparam int DIV_CNT_W   = $clog2(NUM_W);
  localparam int FRAC_W      = 16;
  localparam int SAT_MAG_W   = PROD_W - FRAC_W;
  localparam int CFG_IDX_W   = 3;

  localparam logic [WIDE_W-1:0] WIDE_BOUND = 64'h1000_0000_0000_0000;

  localparam logic CMD_STEP  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D,
    REG_TARGET,
    REG_FLOOR,
    REG_CEIL
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HOLD,
    ST_PROP,
    ST_IGAIN,
    ST_INC,
    ST_DIV,
    ST_DERIV,
    ST_OUT
  } state_e;

  // saturate a magnitude to the intermediate bound and apply the sign
  function automatic logic signed [WIDE_W-1:0] sat_wide(input logic [SAT_MAG_W-1:0] mag,
                                                        input logic neg);
    logic [WIDE_W-1:0] v;
    if (mag > SAT_MAG_W'(WIDE_BOUND)) begin
      v = WIDE_BOUND;
    end else begin
      v = mag[WIDE_W-1:0];
    end
    return neg ? -$signed(v) : $signed(v);
  endfunction

endpackage
`default_nettype wire

### rtl/core/pcci_mul.sv
// Bit-serial signed Q16.16 multiplier, one multiplier bit per cycle.
// Truncates toward zero and saturates to the intermediate bound.
// Depends on pcci_pkg.
`default_nettype none
module pcci_mul (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [pcci_pkg::WIDE_W-1:0]   a_i,
  input  logic signed [pcci_pkg::WIDE_W-1:0]   b_i,
  output logic                                 done_o,
  output logic signed [pcci_pkg::WIDE_W-1:0]   res_o
);

  logic                               busy_q, busy_d, fin_q, fin_d, done_q, done_d;
  logic                               neg_q, neg_d;
  logic [pcci_pkg::MUL_CNT_W-1:0]     cnt_q, cnt_d;
  logic [pcci_pkg::MAG_W-1:0]         ma_q, ma_d, acc_q, acc_d, lo_q, lo_d;
  logic signed [pcci_pkg::WIDE_W-1:0] res_q, res_d;
  logic [pcci_pkg::MAG_W:0]           sum;
  logic [pcci_pkg::PROD_W-1:0]        prod;

  assign sum  = {1'b0, acc_q} + (lo_q[0] ? {1'b0, ma_q} : '0);
  assign prod = {acc_q, lo_q};

  always_comb begin
    busy_d = busy_q;
    fin_d  = fin_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    ma_d   = ma_q;
    acc_d  = acc_q;
    lo_d   = lo_q;
    res_d  = res_q;
    if (start_i) begin
      ma_d   = a_i[pcci_pkg::WIDE_W-1] ? pcci_pkg::MAG_W'(-a_i) : pcci_pkg::MAG_W'(a_i);
      lo_d   = b_i[pcci_pkg::WIDE_W-1] ? pcci_pkg::MAG_W'(-b_i) : pcci_pkg::MAG_W'(b_i);
      neg_d  = a_i[pcci_pkg::WIDE_W-1] ^ b_i[pcci_pkg::WIDE_W-1];
      acc_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
      fin_d  = 1'b0;
    end else if (busy_q) begin
      acc_d = sum[pcci_pkg::MAG_W:1];
      lo_d  = {sum[0], lo_q[pcci_pkg::MAG_W-1:1]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == pcci_pkg::MUL_CNT_W'(pcci_pkg::MAG_W - 1)) begin
        busy_d = 1'b0;
        fin_d  = 1'b1;
      end
    end else if (fin_q) begin
      fin_d  = 1'b0;
      done_d = 1'b1;
      res_d  = pcci_pkg::sat_wide(prod[pcci_pkg::PROD_W-1:pcci_pkg::FRAC_W], neg_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      fin_q  <= fin_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    ma_q  <= ma_d;
    acc_q <= acc_d;
    lo_q  <= lo_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
`default_nettype wire

### rtl/core/pcci_div.sv
// Bit-serial restoring divider for (n << 16) / d, one quotient bit per cycle.
// Truncates toward zero and saturates to the intermediate bound.
// Depends on pcci_pkg.
`default_nettype none
module pcci_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [pcci_pkg::WIDE_W-1:0]   n_i,
  input  logic [pcci_pkg::REG_W-1:0]           d_i,
  output logic                                 done_o,
  output logic signed [pcci_pkg::WIDE_W-1:0]   res_o
);

  logic                               busy_q, busy_d, fin_q, fin_d, done_q, done_d;
  logic                               neg_q, neg_d, ge;
  logic [pcci_pkg::DIV_CNT_W-1:0]     cnt_q, cnt_d;
  logic [pcci_pkg::REG_W-1:0]         dv_q, dv_d, rem_q, rem_d;
  logic [pcci_pkg::NUM_W-1:0]         num_q, num_d;
  logic [pcci_pkg::WIDE_W-1:0]        mn;
  logic [pcci_pkg::REG_W:0]           trial, diff;
  logic signed [pcci_pkg::WIDE_W-1:0] res_q, res_d;

  assign mn    = n_i[pcci_pkg::WIDE_W-1] ? pcci_pkg::WIDE_W'(-n_i) : pcci_pkg::WIDE_W'(n_i);
  assign trial = {rem_q, num_q[pcci_pkg::NUM_W-1]};
  assign ge    = trial >= {1'b0, dv_q};
  assign diff  = trial - {1'b0, dv_q};

  always_comb begin
    busy_d = busy_q;
    fin_d  = fin_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    dv_d   = dv_q;
    rem_d  = rem_q;
    num_d  = num_q;
    res_d  = res_q;
    if (start_i) begin
      num_d  = {mn, pcci_pkg::FRAC_W'(0)};
      dv_d   = (d_i == '0) ? pcci_pkg::REG_W'(1) : d_i;
      rem_d  = '0;
      neg_d  = n_i[pcci_pkg::WIDE_W-1];
      cnt_d  = '0;
      busy_d = 1'b1;
      fin_d  = 1'b0;
    end else if (busy_q) begin
      rem_d = ge ? diff[pcci_pkg::REG_W-1:0] : trial[pcci_pkg::REG_W-1:0];
      num_d = {num_q[pcci_pkg::NUM_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == pcci_pkg::DIV_CNT_W'(pcci_pkg::NUM_W - 1)) begin
        busy_d = 1'b0;
        fin_d  = 1'b1;
      end
    end else if (fin_q) begin
      fin_d  = 1'b0;
      done_d = 1'b1;
      res_d  = pcci_pkg::sat_wide(pcci_pkg::SAT_MAG_W'(num_q), neg_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      fin_q  <= fin_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    dv_q  <= dv_d;
    rem_q <= rem_d;
    num_q <= num_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
`default_nettype wire

### rtl/core/pid_controller_clamped_integral.sv
// Top level of the clamped-integral PID controller (Q16.16).
// Sequencer, configuration and state registers; uses pcci_mul, pcci_div, pcci_pkg.
//
//   channel  | direction | handshake                  | word
//   in       | input     | in_valid_i / in_ready_o    | command, measured_value, step_interval
//   out      | output    | out_valid_o / out_ready_i  | drive_value
//   cfg      | input     | cfg_we_i (no wait)         | cfg_idx_i, cfg_data_i
//
// A step word runs four serial multiplies and one divide through the one shared
// multiplier and divider, one bit a cycle.
// A word with a non-positive interval runs one multiply; a clear word gives no result.
// One word is in work at a time; in_ready_o is high only while idle.
// The result holds in out_valid_o / drive_value_o until taken.
// Reset clears the integral, the previous error and the configuration to defaults.
`default_nettype none
module pid_controller_clamped_integral #(
  parameter int VALUE_WIDTH = pcci_pkg::VALUE_WIDTH
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [pcci_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [pcci_pkg::REG_W-1:0]            cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  command_i,
  input  logic signed [pcci_pkg::REG_W-1:0]     measured_value_i,
  input  logic signed [pcci_pkg::REG_W-1:0]     step_interval_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [pcci_pkg::REG_W-1:0]     drive_value_o
);

  localparam int WW = pcci_pkg::WIDE_W;
  localparam logic signed [WW-1:0] VMAX = (64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1;
  localparam logic signed [WW-1:0] VMIN = -VMAX - 64'sd1;

  pcci_pkg::state_e state_q, state_d;

  logic signed [pcci_pkg::REG_W-1:0] gain_p_q, gain_i_q, gain_d_q, target_q;
  logic signed [pcci_pkg::REG_W-1:0] floor_q, ceil_q;
  logic signed [VALUE_WIDTH-1:0]     integral_q, integral_d, prev_q, prev_d;
  logic signed [VALUE_WIDTH-1:0]     err_q, err_d;
  logic signed [pcci_pkg::REG_W-1:0] dt_q, dt_d, drive_q, drive_d;
  logic signed [WW-1:0]              prop_q, prop_d;

  logic                 mul_start, mul_done, div_start, div_done;
  logic signed [WW-1:0] mul_a, mul_b, mul_res, div_n, div_res;
  logic signed [WW-1:0] err_new, isum, pot, total, sat_tmp;

  function automatic logic signed [WW-1:0] sat_v(input logic signed [WW-1:0] x);
    return (x > VMAX) ? VMAX : ((x < VMIN) ? VMIN : x);
  endfunction

  function automatic logic signed [WW-1:0] clamp_lim(input logic signed [WW-1:0] x,
                                                     input logic signed [WW-1:0] lo,
                                                     input logic signed [WW-1:0] hi);
    return (x > hi) ? hi : ((x < lo) ? lo : x);
  endfunction

  pcci_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  pcci_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .n_i     (div_n),
    .d_i     (dt_q),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  assign err_new = sat_v(WW'(target_q) - WW'(measured_value_i));
  assign div_n   = WW'(err_q) - WW'(prev_q);

  always_comb begin
    state_d    = state_q;
    integral_d = integral_q;
    prev_d     = prev_q;
    err_d      = err_q;
    dt_d       = dt_q;
    prop_d     = prop_q;
    drive_d    = drive_q;
    mul_start  = 1'b0;
    mul_a      = WW'(gain_p_q);
    mul_b      = WW'(err_q);
    div_start  = 1'b0;
    isum       = WW'(integral_q) + mul_res;
    pot        = prop_q + isum;
    total      = '0;
    sat_tmp    = '0;
    case (state_q)
      pcci_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (command_i == pcci_pkg::CMD_CLEAR) begin
            integral_d = '0;
            prev_d     = '0;
          end else if (step_interval_i <= 0) begin
            mul_start = 1'b1;
            mul_b     = WW'(prev_q);
            state_d   = pcci_pkg::ST_HOLD;
          end else begin
            err_d     = err_new[VALUE_WIDTH-1:0];
            dt_d      = step_interval_i;
            mul_start = 1'b1;
            mul_b     = err_new;
            state_d   = pcci_pkg::ST_PROP;
          end
        end
      end
      pcci_pkg::ST_HOLD: begin
        if (mul_done) begin
          total   = mul_res + WW'(integral_q);
          sat_tmp = sat_v(clamp_lim(total, WW'(floor_q), WW'(ceil_q)));
          drive_d = sat_tmp[pcci_pkg::REG_W-1:0];
          state_d = pcci_pkg::ST_OUT;
        end
      end
      pcci_pkg::ST_PROP: begin
        if (mul_done) begin
          prop_d    = mul_res;
          mul_start = 1'b1;
          mul_a     = WW'(gain_i_q);
          state_d   = pcci_pkg::ST_IGAIN;
        end
      end
      pcci_pkg::ST_IGAIN: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = mul_res;
          mul_b     = WW'(dt_q);
          state_d   = pcci_pkg::ST_INC;
        end
      end
      pcci_pkg::ST_INC: begin
        if (mul_done) begin
          if (pot > WW'(ceil_q)) begin
            isum = WW'(ceil_q) - prop_q;
          end else if (pot < WW'(floor_q)) begin
            isum = WW'(floor_q) - prop_q;
          end
          sat_tmp    = sat_v(isum);
          integral_d = sat_tmp[VALUE_WIDTH-1:0];
          div_start  = 1'b1;
          state_d    = pcci_pkg::ST_DIV;
        end
      end
      pcci_pkg::ST_DIV: begin
        if (div_done) begin
          mul_start = 1'b1;
          mul_a     = WW'(gain_d_q);
          mul_b     = div_res;
          state_d   = pcci_pkg::ST_DERIV;
        end
      end
      pcci_pkg::ST_DERIV: begin
        if (mul_done) begin
          total   = prop_q + WW'(integral_q) + mul_res;
          sat_tmp = sat_v(clamp_lim(total, WW'(floor_q), WW'(ceil_q)));
          drive_d = sat_tmp[pcci_pkg::REG_W-1:0];
          prev_d  = err_q;
          state_d = pcci_pkg::ST_OUT;
        end
      end
      pcci_pkg::ST_OUT: begin
        if (out_ready_i) begin
          state_d = pcci_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pcci_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= pcci_pkg::ST_IDLE;
      integral_q <= '0;
      prev_q     <= '0;
    end else begin
      state_q    <= state_d;
      integral_q <= integral_d;
      prev_q     <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q   <= err_d;
    dt_q    <= dt_d;
    prop_q  <= prop_d;
    drive_q <= drive_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q <= '0;
      gain_i_q <= '0;
      gain_d_q <= '0;
      target_q <= '0;
      floor_q  <= {1'b1, {(pcci_pkg::REG_W - 1){1'b0}}};
      ceil_q   <= {1'b0, {(pcci_pkg::REG_W - 1){1'b1}}};
    end else if (cfg_we_i) begin
      case (pcci_pkg::cfg_reg_e'(cfg_idx_i))
        pcci_pkg::REG_GAIN_P: gain_p_q <= cfg_data_i;
        pcci_pkg::REG_GAIN_I: gain_i_q <= cfg_data_i;
        pcci_pkg::REG_GAIN_D: gain_d_q <= cfg_data_i;
        pcci_pkg::REG_TARGET: target_q <= cfg_data_i;
        pcci_pkg::REG_FLOOR:  floor_q  <= cfg_data_i;
        pcci_pkg::REG_CEIL:   ceil_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign in_ready_o    = (state_q == pcci_pkg::ST_IDLE);
  assign out_valid_o   = (state_q == pcci_pkg::ST_OUT);
  assign drive_value_o = drive_q;

`ifndef SYNTHESIS
  a_clear_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && command_i == pcci_pkg::CMD_CLEAR)
      |=> (integral_q == '0 && prev_q == '0))
    else $error("clear word left state non-zero");

  a_hold_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && command_i == pcci_pkg::CMD_STEP && step_interval_i <= 0)
      |=> ($stable(integral_q) && $stable(prev_q)))
    else $error("hold step changed state");

  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_done && div_done))
    else $error("multiplier and divider finished together");

  a_mul_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == pcci_pkg::ST_HOLD || state_q == pcci_pkg::ST_PROP ||
                  state_q == pcci_pkg::ST_IGAIN || state_q == pcci_pkg::ST_INC ||
                  state_q == pcci_pkg::ST_DERIV))
    else $error("multiplier result arrived outside a multiply state");
`endif

endmodule
`default_nettype wire

### bench/tb_pid_controller_clamped_integral.sv
// Self-checking bench for the clamped-integral PID controller (Q16.16).
// Predicts each drive word from its own integral/error state and checks the outputs.
// Depends on pcci_pkg and pid_controller_clamped_integral.
`timescale 1ns / 1ps
module tb_pid_controller_clamped_integral;

  localparam longint SAT_BOUND = 64'sh1000_0000_0000_0000;
  localparam int     SETTLE    = 400;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             cfg_we_i = 1'b0;
  pcci_pkg::cfg_reg_e               cfg_idx_i = pcci_pkg::REG_GAIN_P;
  logic [pcci_pkg::REG_W-1:0]       cfg_data_i = '0;
  logic                             in_valid_i = 1'b0;
  logic                             in_ready_o;
  logic                             command_i = pcci_pkg::CMD_STEP;
  logic signed [pcci_pkg::REG_W-1:0] measured_value_i = '0;
  logic signed [pcci_pkg::REG_W-1:0] step_interval_i = '0;
  logic                             out_valid_o;
  logic                             out_ready_i = 1'b0;
  logic signed [pcci_pkg::REG_W-1:0] drive_value_o;

  pid_controller_clamped_integral dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .command_i, .measured_value_i, .step_interval_i,
    .out_valid_o, .out_ready_i, .drive_value_o
  );

  // controller copy
  longint kp, ki, kd, setpoint, floor_lim, ceil_lim;
  longint integ_acc, last_err;
  logic signed [pcci_pkg::REG_W-1:0] drive_expect_q[$];
  int errors = 0;
  int burst_left = 0;

  initial forever #2 clk_i = ~clk_i;

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint clamp_drive(longint x);
    if (x > ceil_lim) return ceil_lim;
    if (x < floor_lim) return floor_lim;
    return x;
  endfunction

  function automatic longint sat_mag(logic [127:0] m, logic neg);
    longint v;
    v = (m > 128'h1000_0000_0000_0000) ? SAT_BOUND : longint'(m[63:0]);
    return neg ? -v : v;
  endfunction

  function automatic longint q_mul(longint a, longint b);
    logic [63:0]  ma, mb;
    logic [127:0] p;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p = {64'd0, ma} * {64'd0, mb};
    return sat_mag(p >> 16, (a < 0) != (b < 0));
  endfunction

  function automatic longint q_div(longint n, longint d);
    logic [63:0]  mn;
    logic [127:0] num;
    mn = (n < 0) ? -n : n;
    num = {48'd0, mn, 16'd0};
    return sat_mag(num / {64'd0, d[63:0]}, n < 0);
  endfunction

  task automatic predict_drive(logic cmd, longint meas, longint dt);
    longint err, prop, isum, deriv;
    if (cmd == pcci_pkg::CMD_CLEAR) begin
      integ_acc = 0;
      last_err = 0;
      return;
    end
    if (dt <= 0) begin
      drive_expect_q.push_back(
        pcci_pkg::REG_W'(sat32(clamp_drive(q_mul(kp, last_err) + integ_acc))));
      return;
    end
    err = sat32(setpoint - meas);
    prop = q_mul(kp, err);
    isum = integ_acc + q_mul(q_mul(ki, err), dt);
    if (prop + isum > ceil_lim) isum = ceil_lim - prop;
    else if (prop + isum < floor_lim) isum = floor_lim - prop;
    integ_acc = sat32(isum);
    deriv = q_mul(kd, q_div(err - last_err, dt));
    drive_expect_q.push_back(
      pcci_pkg::REG_W'(sat32(clamp_drive(prop + integ_acc + deriv))));
    last_err = err;
  endtask

  task automatic report(string what);
    errors++;
    $display("%0t mismatch: %s", $realtime, what);
  endtask

  // receiver: checks each taken drive word; the stall pattern is re-picked at random
  int rx_cycle = 0;
  int rx_mode = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (drive_expect_q.size() == 0) begin
          report($sformatf("unexpected drive %h", drive_value_o));
        end else begin
          if (drive_value_o !== drive_expect_q[0])
            report($sformatf("drive_value %h, want %h", drive_value_o, drive_expect_q[0]));
          void'(drive_expect_q.pop_front());
        end
      end
      rx_cycle++;
      if (rx_cycle % 200 == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= $urandom_range(0, 1);
        2: out_ready_i <= ($urandom_range(0, 3) == 0);
        default: out_ready_i <= ($urandom_range(0, 15) != 0);
      endcase
    end
  end

  task automatic send_word(logic cmd, logic [31:0] meas, logic [31:0] dt);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 4) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 6))
        @(posedge clk_i);
      burst_left = $urandom_range(1, 30);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    measured_value_i <= meas;
    step_interval_i <= dt;
    do @(posedge clk_i); while (!in_ready_o);
    predict_drive(cmd, longint'($signed(meas)), longint'($signed(dt)));
    burst_left--;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (drive_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_reg(pcci_pkg::cfg_reg_e idx, logic [31:0] val);
    longint v;
    v = longint'($signed(val));
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      pcci_pkg::REG_GAIN_P: kp = v;
      pcci_pkg::REG_GAIN_I: ki = v;
      pcci_pkg::REG_GAIN_D: kd = v;
      pcci_pkg::REG_TARGET: setpoint = v;
      pcci_pkg::REG_FLOOR:  floor_lim = v;
      pcci_pkg::REG_CEIL:   ceil_lim = v;
      default: ;
    endcase
  endtask

  task automatic load_all(logic [31:0] p, logic [31:0] i, logic [31:0] d, logic [31:0] t,
                          logic [31:0] lo, logic [31:0] hi);
    wait_idle();
    set_reg(pcci_pkg::REG_GAIN_P, p);
    set_reg(pcci_pkg::REG_GAIN_I, i);
    set_reg(pcci_pkg::REG_GAIN_D, d);
    set_reg(pcci_pkg::REG_TARGET, t);
    set_reg(pcci_pkg::REG_FLOOR, lo);
    set_reg(pcci_pkg::REG_CEIL, hi);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_defaults();
    send_word(pcci_pkg::CMD_STEP, 32'h8000_0000, 32'h0000_0001);
    send_word(pcci_pkg::CMD_STEP, 32'h7fff_ffff, 32'h7fff_ffff);
    send_word(pcci_pkg::CMD_STEP, 32'h0000_0000, 32'h0000_0000);
    send_word(pcci_pkg::CMD_STEP, 32'hffff_ffff, 32'h8000_0000);
  endtask

  task automatic test_hold_and_clear();
    load_all(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h0064_0000,
             32'h8000_0000, 32'h7fff_ffff);
    send_word(pcci_pkg::CMD_STEP, 32'h0010_0000, 32'h0000_4000);
    send_word(pcci_pkg::CMD_STEP, 32'h0020_0000, 32'h0001_0000);
    send_word(pcci_pkg::CMD_STEP, 32'h1234_5678, 32'h0000_0000);
    send_word(pcci_pkg::CMD_STEP, 32'h0000_0000, 32'hffff_0000);
    send_word(pcci_pkg::CMD_CLEAR, 32'hdead_beef, 32'h0001_0000);
    send_word(pcci_pkg::CMD_STEP, 32'h0000_0000, 32'h0000_0000);
    send_word(pcci_pkg::CMD_STEP, 32'hffd0_0000, 32'h0000_0100);
  endtask

  task automatic test_limits();
    load_all(32'h0000_8000, 32'h0040_0000, 32'h0000_0000, 32'h0010_0000,
             32'hfff0_0000, 32'h0008_0000);
    send_word(pcci_pkg::CMD_STEP, 32'h8000_0000, 32'h0001_0000);
    send_word(pcci_pkg::CMD_STEP, 32'h7fff_ffff, 32'h0001_0000);
    send_word(pcci_pkg::CMD_STEP, 32'h0010_0000, 32'h0000_0000);
    // floor above ceiling
    load_all(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0000_0000,
             32'h0005_0000, 32'hfffb_0000);
    send_word(pcci_pkg::CMD_STEP, 32'hfff0_0000, 32'h0001_0000);
    send_word(pcci_pkg::CMD_STEP, 32'h0010_0000, 32'h0001_0000);
    send_word(pcci_pkg::CMD_STEP, 32'h0000_0000, 32'h0001_0000);
    // widest gains and intervals drive the intermediate saturation
    load_all(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
             32'h8000_0000, 32'h7fff_ffff);
    send_word(pcci_pkg::CMD_STEP, 32'h8000_0000, 32'h0000_0001);
    send_word(pcci_pkg::CMD_STEP, 32'h7fff_ffff, 32'h0000_0001);
    send_word(pcci_pkg::CMD_STEP, 32'h8000_0000, 32'h7fff_ffff);
    send_word(pcci_pkg::CMD_STEP, 32'h0000_0000, 32'h8000_0001);
  endtask

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h0;
      default: return 32'($signed($urandom_range(0, 32'h8_0000)) - 32'sh4_0000);
    endcase
  endfunction

  task automatic test_random(int words);
    logic [31:0] lo, hi, meas, dt;
    int phase_left;
    phase_left = 0;
    for (int n = 0; n < words; n++) begin
      if (phase_left == 0) begin
        case ($urandom_range(0, 3))
          0: begin lo = 32'h8000_0000; hi = 32'h7fff_ffff; end
          1: begin lo = $urandom; hi = $urandom; end
          default: begin
            lo = 32'($signed($urandom_range(0, 32'h0100_0000)) - 32'sh0100_0000);
            hi = $urandom_range(0, 32'h0100_0000);
          end
        endcase
        load_all(pick_gain(), pick_gain(), pick_gain(),
                 $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0020_0000), lo, hi);
        phase_left = $urandom_range(100, 300);
      end
      phase_left--;
      meas = ($urandom_range(0, 9) < 7)
             ? 32'(setpoint + $signed($urandom_range(0, 32'h20_0000)) - 32'sh10_0000)
             : $urandom;
      case ($urandom_range(0, 9))
        0: dt = $urandom_range(0, 1) ? 32'h0 : ($urandom | 32'h8000_0000);
        1, 2: dt = $urandom;
        default: dt = $urandom_range(1, 32'h2_0000);
      endcase
      send_word(($urandom_range(0, 24) == 0) ? pcci_pkg::CMD_CLEAR : pcci_pkg::CMD_STEP,
                meas, dt);
    end
  endtask

  initial begin
    kp = 0; ki = 0; kd = 0; setpoint = 0;
    floor_lim = -64'sd2147483648; ceil_lim = 64'sd2147483647;
    integ_acc = 0; last_err = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults();
    test_hold_and_clear();
    test_limits();
    test_random(1700);
    wait_idle();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
